/* src/cpps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpps_pkg: shared types and constants
// Holds the block sizes, the sequencer state type and register address codes.
// ----------------------------------------------------------------------------
package cpps_pkg;

  localparam int unsigned PIXEL_COUNT  = 512;
  localparam int unsigned CLUSTER_SIZE = 16;
  localparam int unsigned TRACE_LENGTH = 32;
  localparam int unsigned SAMPLE_BITS  = 12;

  localparam int unsigned RegAddrW = 4;

  localparam logic [RegAddrW-1:0] REG_THRESH = 4'h0;
  localparam logic [RegAddrW-1:0] REG_COINC  = 4'h4;
  localparam logic [RegAddrW-1:0] REG_WSTART = 4'h8;
  localparam logic [RegAddrW-1:0] REG_WEND   = 4'hC;

  localparam logic OP_BASELINE = 1'b0;
  localparam logic OP_SAMPLE   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_CHARGE,
    ST_CLEAR,
    ST_OUT
  } state_e;

endpackage

/* src/cpps_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpps_ram: generic single-port RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module cpps_ram #(
  parameter int unsigned Width = 14,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

/* src/coincident_pixel_pair_selector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coincident_pixel_pair_selector: picks the brightest coincident pixel pair
// Tracks per-channel peak and window sum; at event end scans the pairs.
// ----------------------------------------------------------------------------
// Channel  | Direction | Content
// s_axis   | in        | baseline beat or event sample beat
// m_axis   | out       | one result beat per event end
// apb      | in/out    | four configuration registers
//
// A baseline beat is taken in ST_IDLE alone; a sample beat is read in ST_IDLE,
// then ST_UPDATE does the read-modify-write of the channel state. A final sample
// adds a scan of CLUSTER_SIZE channels, each in ST_SCAN then ST_CHARGE (baseline
// RAM read then compare through one shared charge unit), then ST_CLEAR clears the
// state of every channel and ST_OUT loads the result register.
// The scan visits channel k, then k+8, so that equal charges keep the pair order.
// A waiting result stalls the block only when the next event ends before
// the result beat is taken.
// Reset is asynchronous active low; it clears control and sets config defaults.
// ----------------------------------------------------------------------------
module coincident_pixel_pair_selector
  import cpps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [0] operation
  input  logic        s_axis_tuser_i,
  input  logic        s_axis_tlast_i,
  // chip[5:0], channel[9:6], idx[14:10], value[26:15], bpix[35:27], bval[49:36]
  input  logic [55:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // found[0], fired_pixel[9:1], in_second_chip[10], max_charge[28:11],
  // pair_count[32:29]
  output logic [39:0] m_axis_tdata_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  localparam int unsigned ChipSize = CLUSTER_SIZE / 2;
  localparam int unsigned ChW  = $clog2(CLUSTER_SIZE);
  localparam int unsigned PixW = $clog2(PIXEL_COUNT);
  localparam int unsigned SumW = 17;
  localparam logic [SumW-1:0] SumMax = '1;

  // configuration
  logic [11:0] thresh_q;
  logic [4:0]  coinc_q, wstart_q;
  logic [5:0]  wend_q;
  logic        wr;
  assign wr = psel_i && penable_i && pwrite_i;
  assign pready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= 12'd510;
      coinc_q  <= 5'd5;
      wstart_q <= 5'd4;
      wend_q   <= 6'd10;
    end else if (wr) begin
      case (paddr_i)
        REG_THRESH: thresh_q <= pwdata_i[11:0];
        REG_COINC:  coinc_q  <= pwdata_i[4:0];
        REG_WSTART: wstart_q <= pwdata_i[4:0];
        REG_WEND:   wend_q   <= pwdata_i[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr_i)
      REG_THRESH: prdata_o = {20'd0, thresh_q};
      REG_COINC:  prdata_o = {27'd0, coinc_q};
      REG_WSTART: prdata_o = {27'd0, wstart_q};
      REG_WEND:   prdata_o = {26'd0, wend_q};
      default:    prdata_o = '0;
    endcase
  end

  // input fields
  logic [5:0]             in_chip;
  logic [3:0]             in_ch;
  logic [4:0]             in_idx;
  logic [11:0]            in_val;
  logic [8:0]             in_bpix;
  logic [13:0]            in_bval;
  assign in_chip = s_axis_tdata_i[5:0];
  assign in_ch   = s_axis_tdata_i[9:6];
  assign in_idx  = s_axis_tdata_i[14:10];
  assign in_val  = s_axis_tdata_i[26:15];
  assign in_bpix = s_axis_tdata_i[35:27];
  assign in_bval = s_axis_tdata_i[49:36];

  // per-channel state
  logic [11:0]     pk_val_q [CLUSTER_SIZE];
  logic [4:0]      pk_idx_q [CLUSTER_SIZE];
  logic [SumW-1:0] sum_q    [CLUSTER_SIZE];

  state_e state_q, state_d;
  logic [5:0]  chip_q;
  logic [3:0]  ch_q;
  logic [4:0]  idx_q;
  logic [11:0] val_q;
  logic        last_q, inwin_q;
  logic [ChW:0] cnt_q;
  logic [3:0]  pairs_q;
  logic        found_q, qual_q;
  logic signed [21:0] best_q;
  logic [ChW-1:0] best_ch_q;
  logic [39:0] out_q;
  logic        ovalid_q;
  logic        out_load;
  logic [39:0] res_word;

  logic accept;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  // The result register is loaded once the previous beat has left it.
  assign out_load = (state_q == ST_OUT) && (!ovalid_q || m_axis_tready_i);

  // baseline RAM
  logic            ram_we;
  logic [PixW-1:0] ram_addr;
  logic [13:0]     ram_rdata;
  logic [ChW-1:0]  cur;
  logic [ChW-1:0]  scan_ch;
  assign cur = cnt_q[ChW-1:0];
  // Scan order 0, 8, 1, 9, ... keeps each pair's candidates adjacent.
  assign scan_ch = {cnt_q[0], cnt_q[ChW-1:1]};

  always_comb begin
    ram_we = accept && (s_axis_tuser_i == OP_BASELINE);
    if (state_q == ST_SCAN) begin
      ram_addr = PixW'(({3'd0, chip_q} * 9'(ChipSize)) + 9'(scan_ch));
    end else begin
      ram_addr = PixW'(in_bpix);
    end
  end

  cpps_ram #(.Width(14), .Depth(PIXEL_COUNT)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (in_bval),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && s_axis_tuser_i == OP_SAMPLE) state_d = ST_UPDATE;
      end
      ST_UPDATE: state_d = last_q ? ST_SCAN : ST_IDLE;
      ST_SCAN:   state_d = ST_CHARGE;
      ST_CHARGE: state_d = (cur == ChW'(CLUSTER_SIZE - 1)) ? ST_CLEAR : ST_SCAN;
      ST_CLEAR:  state_d = (cur == ChW'(CLUSTER_SIZE - 1)) ? ST_OUT : ST_CLEAR;
      ST_OUT:    state_d = out_load ? ST_IDLE : ST_OUT;
      default:   state_d = ST_IDLE;
    endcase
  end

  // shared charge unit: 4*sum - width*baseline
  logic [5:0]  width;
  logic signed [21:0] charge;
  logic [4:0]  adiff;
  logic        qual;
  logic [ChW-1:0] mate;
  assign width = (wend_q > {1'b0, wstart_q}) ? (wend_q - {1'b0, wstart_q}) : 6'd0;
  assign charge = $signed({3'd0, sum_q[scan_ch], 2'b00})
                - $signed({2'b0, ({14'd0, width} * {6'd0, ram_rdata})});
  assign mate = scan_ch ^ ChW'(ChipSize);
  assign adiff = (pk_idx_q[scan_ch] > pk_idx_q[mate]) ? pk_idx_q[scan_ch] - pk_idx_q[mate]
                                                      : pk_idx_q[mate] - pk_idx_q[scan_ch];
  assign qual = (adiff < coinc_q) && (pk_val_q[scan_ch] > thresh_q)
             && (pk_val_q[mate] > thresh_q);

  logic [SumW:0] sum_add;
  assign sum_add = {1'b0, sum_q[ch_q]} + {{(SumW-11){1'b0}}, val_q};

  logic signed [21:0] sat;
  assign sat = (best_q > 22'sd98303) ? 22'sd98303 : best_q;

  // result word
  always_comb begin
    res_word = '0;
    res_word[32:29] = pairs_q;
    if (found_q) begin
      res_word[0]     = 1'b1;
      res_word[9:1]   = 9'(({3'd0, chip_q} * 9'(ChipSize))
                        + 9'(best_ch_q % ChW'(ChipSize)));
      res_word[10]    = (best_ch_q >= ChW'(ChipSize));
      res_word[28:11] = sat[17:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ovalid_q  <= 1'b0;
      chip_q    <= '0;
      cnt_q     <= '0;
      ch_q      <= '0;
      idx_q     <= '0;
      val_q     <= '0;
      last_q    <= 1'b0;
      inwin_q   <= 1'b0;
      pairs_q   <= '0;
      found_q   <= 1'b0;
      qual_q    <= 1'b0;
      best_q    <= '0;
      best_ch_q <= '0;
      out_q     <= '0;
      for (int i = 0; i < CLUSTER_SIZE; i++) begin
        pk_val_q[i] <= '0;
        pk_idx_q[i] <= '0;
        sum_q[i]    <= '0;
      end
    end else begin
      state_q  <= state_d;
      ovalid_q <= out_load ? 1'b1 : (m_axis_tready_i ? 1'b0 : ovalid_q);
      case (state_q)
        ST_IDLE: begin
          if (accept && s_axis_tuser_i == OP_SAMPLE) begin
            chip_q  <= in_chip;
            ch_q    <= in_ch;
            idx_q   <= in_idx;
            val_q   <= in_val;
            last_q  <= s_axis_tlast_i;
            inwin_q <= ({1'b0, in_idx} >= {1'b0, wstart_q}) && ({1'b0, in_idx} < wend_q);
            cnt_q   <= '0;
            pairs_q <= '0;
            found_q <= 1'b0;
            best_q  <= '0;
            best_ch_q <= '0;
          end
        end
        ST_UPDATE: begin
          if (inwin_q) begin
            sum_q[ch_q] <= sum_add[SumW] ? SumMax : sum_add[SumW-1:0];
            if (val_q > pk_val_q[ch_q] || (val_q == pk_val_q[ch_q] && val_q != '0
                && idx_q < pk_idx_q[ch_q])) begin
              pk_val_q[ch_q] <= val_q;
              pk_idx_q[ch_q] <= idx_q;
            end
          end
        end
        ST_SCAN: qual_q <= qual;
        ST_CHARGE: begin
          if (qual_q) begin
            if (scan_ch < ChW'(ChipSize)) pairs_q <= pairs_q + 4'd1;
            if (charge > best_q) begin
              best_q    <= charge;
              best_ch_q <= scan_ch;
              found_q   <= 1'b1;
            end
          end
          cnt_q <= (cur == ChW'(CLUSTER_SIZE - 1)) ? '0 : cnt_q + 1'b1;
        end
        ST_CLEAR: begin
          pk_val_q[cur] <= '0;
          pk_idx_q[cur] <= '0;
          sum_q[cur]    <= '0;
          cnt_q <= cnt_q + 1'b1;
        end
        ST_OUT: if (out_load) out_q <= res_word;
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = out_q;

endmodule

/* sim/coincident_pixel_pair_selector_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coincident_pixel_pair_selector_tb: self-checking bench for the pair selector
// Loads baselines, streams event samples under random idling and bursts, and
// compares every result beat against a cycle-free prediction of the block.
// ----------------------------------------------------------------------------
module coincident_pixel_pair_selector_tb
  import cpps_pkg::*;
();

  localparam int unsigned NumPix  = 512;
  localparam int unsigned ChipW   = 8;
  localparam int unsigned SumMax  = 131071;
  localparam int          ChgMax  = 98303;
  localparam int          ChgMin  = -98304;
  localparam int unsigned IdleMax = 5000;

  // One input beat, unpacked.
  typedef struct packed {
    logic        op;
    logic [5:0]  chip;
    logic [3:0]  chan;
    logic [4:0]  idx;
    logic [11:0] value;
    logic        last;
    logic [8:0]  bpix;
    logic [13:0] bval;
  } beat_t;

  // One result beat, unpacked.
  typedef struct packed {
    logic        found;
    logic [8:0]  pixel;
    logic        second;
    logic [17:0] charge;
    logic [3:0]  pairs;
  } hit_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic        s_axis_tuser_i = 1'b0;
  logic        s_axis_tlast_i = 1'b0;
  logic [55:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic        psel_i = 1'b0;
  logic        penable_i = 1'b0;
  logic        pwrite_i = 1'b0;
  logic [3:0]  paddr_i = '0;
  logic [31:0] pwdata_i = '0;
  logic [31:0] prdata_o;
  logic        pready_o;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  coincident_pixel_pair_selector DUT (.*);

  // Predictor state: a shadow of the block's tables and registers.
  logic [13:0] base_tab [NumPix];
  logic [11:0] pk_val   [16];
  logic [4:0]  pk_idx   [16];
  logic [16:0] win_sum  [16];
  logic [5:0]  cur_chip;
  logic [11:0] thresh;
  logic [4:0]  coinc;
  logic [4:0]  w_start;
  logic [5:0]  w_end;

  hit_t        hits_due[$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit          long_hold = 1'b0;
  bit          random_stall = 1'b0;

  function automatic logic [8:0] pixel_at(logic [5:0] chip, int unsigned ch);
    return 9'((int'(chip) * ChipW + ch) % NumPix);
  endfunction

  // Advances the shadow by one beat and queues the result it produces.
  function automatic void predict_beat(beat_t b);
    int unsigned width, pairs, best_ch, diff, c, s;
    longint      best, q;
    bit          found;
    hit_t        h;
    if (b.op == OP_BASELINE) begin
      base_tab[b.bpix] = b.bval;
      return;
    end
    cur_chip = b.chip;
    if (b.idx >= w_start && b.idx < w_end) begin
      s = win_sum[b.chan] + b.value;
      win_sum[b.chan] = (s > SumMax) ? 17'(SumMax) : 17'(s);
      if (b.value > pk_val[b.chan] ||
          (b.value == pk_val[b.chan] && b.value != 0 && b.idx < pk_idx[b.chan])) begin
        pk_val[b.chan] = b.value;
        pk_idx[b.chan] = b.idx;
      end
    end
    if (!b.last) return;
    width = (w_end > w_start) ? w_end - w_start : 0;
    pairs = 0; best_ch = 0; best = 0; found = 1'b0;
    for (int k = 0; k < ChipW; k++) begin
      diff = (pk_idx[k] > pk_idx[k+8]) ? pk_idx[k] - pk_idx[k+8] : pk_idx[k+8] - pk_idx[k];
      if (diff < coinc && pk_val[k] > thresh && pk_val[k+8] > thresh) begin
        pairs++;
        for (int hh = 0; hh < 2; hh++) begin
          c = k + hh * ChipW;
          q = longint'(win_sum[c]) * 4 - longint'(width) * base_tab[pixel_at(cur_chip, c)];
          if (q > best) begin
            best = q; best_ch = c; found = 1'b1;
          end
        end
      end
    end
    h = '0;
    if (found) begin
      h.found  = 1'b1;
      h.pixel  = pixel_at(cur_chip, best_ch % ChipW);
      h.second = best_ch >= ChipW;
      h.charge = 18'((best > ChgMax) ? ChgMax : ((best < ChgMin) ? ChgMin : best));
    end
    h.pairs = 4'(pairs);
    hits_due = {hits_due, h};
    for (int i = 0; i < 16; i++) begin
      pk_val[i] = '0; pk_idx[i] = '0; win_sum[i] = '0;
    end
  endfunction

  // Sends one beat and waits for its handshake; the sender bursts and pauses.
  int unsigned burst_left = 0;
  task automatic send_beat(beat_t b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= b.op;
    s_axis_tlast_i  <= b.last;
    s_axis_tdata_i  <= {6'b0, b.bval, b.bpix, b.value, b.idx, b.chan, b.chip};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_beat(b);
  endtask

  // Writes one register through the APB port.
  task automatic write_reg(logic [3:0] addr, logic [31:0] data);
    psel_i <= 1'b1; penable_i <= 1'b0; pwrite_i <= 1'b1;
    paddr_i <= addr; pwdata_i <= data;
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    case (addr)
      REG_THRESH: thresh  = data[11:0];
      REG_COINC:  coinc   = data[4:0];
      REG_WSTART: w_start = data[4:0];
      default:    w_end   = data[5:0];
    endcase
  endtask

  // Stops offering beats, waits for all results, then lets the block settle.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (hits_due.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic set_regs(int th, int co, int ws, int we);
    drain();
    write_reg(REG_THRESH, th);
    write_reg(REG_COINC, co);
    write_reg(REG_WSTART, ws);
    write_reg(REG_WEND, we);
    psel_i <= 1'b0; penable_i <= 1'b0; pwrite_i <= 1'b0;
  endtask

  function automatic beat_t sample_beat(logic [5:0] chip, logic [3:0] ch, logic [4:0] idx,
                                        logic [11:0] v, logic last);
    beat_t b;
    b = '0;
    b.op = OP_SAMPLE; b.chip = chip; b.chan = ch; b.idx = idx; b.value = v; b.last = last;
    b.bpix = 9'($urandom); b.bval = 14'($urandom);
    return b;
  endfunction

  // Baselines for the whole table are loaded first, so that no event ever
  // reads an entry that was never written.
  task automatic test_baselines();
    beat_t b;
    for (int p = 0; p < NumPix; p++) begin
      b = '0;
      b.op = OP_BASELINE;
      b.bpix = 9'(p);
      b.chip = 6'($urandom); b.chan = 4'($urandom); b.idx = 5'($urandom);
      b.value = 12'($urandom); b.last = 1'($urandom);
      case (p % 4)
        0: b.bval = 14'h3FFF;
        1: b.bval = '0;
        default: b.bval = 14'($urandom_range(0, 4000));
      endcase
      send_beat(b);
    end
  endtask

  // Directed events: extremes, ties, saturation, empty window.
  task automatic test_directed();
    // Full-scale samples on every pair near the top of the pixel range.
    for (int c = 0; c < 16; c++) send_beat(sample_beat(6'd62, 4'(c), 5'd5, 12'hFFF, 1'b0));
    send_beat(sample_beat(6'd62, 4'd0, 5'd6, 12'hFFF, 1'b1));
    // Equal peaks arriving late index first: the lower index must win.
    send_beat(sample_beat(6'd0, 4'd3, 5'd8, 12'd2000, 1'b0));
    send_beat(sample_beat(6'd0, 4'd3, 5'd5, 12'd2000, 1'b0));
    send_beat(sample_beat(6'd0, 4'd11, 5'd9, 12'd2000, 1'b0));
    // Outside the window, but it still ends the event.
    send_beat(sample_beat(6'd0, 4'd11, 5'd31, 12'd4000, 1'b1));
    // Nothing at all: an empty event.
    send_beat(sample_beat(6'd7, 4'd0, 5'd0, 12'd0, 1'b1));
    // Sum saturation with a wide window.
    set_regs(0, 31, 0, 32);
    for (int i = 0; i < 80; i++) begin
      send_beat(sample_beat(6'd1, (i % 2) ? 4'd9 : 4'd1, 5'(i % 32), 12'hFFF, 1'b0));
    end
    send_beat(sample_beat(6'd1, 4'd15, 5'd31, 12'hFFF, 1'b1));
    // Empty window and zero coincidence window.
    set_regs(4095, 0, 20, 3);
    send_beat(sample_beat(6'd33, 4'd2, 5'd20, 12'd100, 1'b1));
  endtask

  // Random events: mostly well-formed clusters with random content.
  task automatic test_random(int n_beats);
    int   sent;
    logic [5:0] chip;
    sent = 0;
    while (sent < n_beats) begin
      chip = 6'($urandom_range(0, 62));
      repeat ($urandom_range(4, 40)) begin
        logic [3:0] ch;
        logic [11:0] v;
        ch = 4'($urandom);
        v = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(300, 1200));
        send_beat(sample_beat(($urandom_range(0, 9) == 0) ? 6'($urandom) : chip, ch,
                              5'($urandom), v, 1'b0));
        sent++;
      end
      if ($urandom_range(0, 5) == 0) begin
        beat_t b;
        b = '0; b.op = OP_BASELINE; b.bpix = 9'($urandom); b.bval = 14'($urandom);
        send_beat(b);
        sent++;
      end
      send_beat(sample_beat(chip, 4'($urandom), 5'($urandom), 12'($urandom), 1'b1));
      sent++;
    end
  endtask

  // The receiver stalls on its own pattern, with one long hold-off.
  always @(posedge clk_i) begin
    if (long_hold) m_axis_tready_i <= 1'b0;
    else if (random_stall) m_axis_tready_i <= ($urandom_range(0, 3) != 0);
    else m_axis_tready_i <= 1'b1;
  end

  // Result checker: compares each accepted beat with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      hit_t got, want;
      got = {m_axis_tdata_o[32:29], m_axis_tdata_o[28:11], m_axis_tdata_o[10],
             m_axis_tdata_o[9:1], m_axis_tdata_o[0]} ;
      got.found  = m_axis_tdata_o[0];
      got.pixel  = m_axis_tdata_o[9:1];
      got.second = m_axis_tdata_o[10];
      got.charge = m_axis_tdata_o[28:11];
      got.pairs  = m_axis_tdata_o[32:29];
      if (hits_due.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = hits_due.pop_front();
        if (got != want) begin
          $display("%0t: mismatch expected found=%0d pix=%0d sec=%0d q=%0d pairs=%0d",
                   $time, want.found, want.pixel, want.second,
                   $signed(want.charge), want.pairs);
          $display("%0t:          actual found=%0d pix=%0d sec=%0d q=%0d pairs=%0d",
                   $time, got.found, got.pixel, got.second,
                   $signed(got.charge), got.pairs);
          errors++;
        end
      end
    end
  end

  // Watchdog: too long with no beat accepted on either side ends the run.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IdleMax) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < 16; i++) begin
      pk_val[i] = '0; pk_idx[i] = '0; win_sum[i] = '0;
    end
    cur_chip = '0; thresh = 510; coinc = 5; w_start = 4; w_end = 10;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_baselines();
    random_stall = 1'b1;
    test_directed();
    set_regs(510, 5, 4, 10);
    test_random(350);
    // Long hold-off while events keep coming, so the block backs up.
    fork
      begin
        long_hold = 1'b1;
        repeat (600) @(posedge clk_i);
        long_hold = 1'b0;
      end
      test_random(60);
    join
    set_regs(4095, 31, 31, 32);
    test_random(100);
    set_regs(0, 1, 0, 32);
    test_random(200);
    set_regs($urandom_range(200, 900), 8, 2, 20);
    random_stall = 1'b0;
    test_random(150);
    random_stall = 1'b1;
    set_regs(700, 3, 10, 11);
    test_random(150);
    drain();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
